/* design/multicart_bank_switch_mapper_top_macros.svh */
// Assertion helpers for the mapper top level
`ifndef MULTICART_BANK_SWITCH_MAPPER_TOP_MACROS_SVH
`define MULTICART_BANK_SWITCH_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MCBSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MCBSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mcbsm_pkg.sv */
`default_nettype none

package mcbsm_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int MADDR_W = 20;

  // ROM sizes in banks
  localparam int PRG_BANKS_8K = 128;
  localparam int CHR_BANKS_1K = 1024;

  // Bank number widths, fixed by the 20-bit physical address
  localparam int PRG_BANK_W  = 7;
  localparam int CHR_BANK_W  = 10;
  localparam int PRG_SPAN    = 1 << PRG_BANK_W;
  localparam int CHR_INNER_W = 7;
  localparam int CHR_INNER_N = 1 << CHR_INNER_W;
  localparam int OUTER_BASE_N = 8;

  // Register write decode
  localparam logic [ADDR_W-1:0] ADDR_MASK_BANK = 16'hE001;
  localparam logic [ADDR_W-1:0] ADDR_BANK_SEL  = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_BANK_DATA = 16'h8001;

  // Fixed PRG banks
  localparam logic [3:0] PRG_FIXED_2ND_LAST = 4'hE;
  localparam logic [3:0] PRG_FIXED_LAST     = 4'hF;

  // Bank register reset contents, entry 7 first
  localparam logic [7:0][DATA_W-1:0] BANK_REGS_RESET =
    {8'd0, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_WRITE = 2'd0,
    CMD_CPU_READ  = 2'd1,
    CMD_PPU_READ  = 2'd2
  } cmd_t;

  // One input word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
    logic              prg_ram_write_enable;
  } item_t;

  // Mapper state seen by the translator
  typedef struct packed {
    logic [5:0]              outer_select;
    logic [DATA_W-1:0]       bank_select;
    logic [7:0][DATA_W-1:0]  bank_regs;
  } map_state_t;

  // Bank wrap tables, computed at elaboration
  typedef logic [PRG_BANK_W-1:0] prg_tab_t [PRG_SPAN];
  typedef logic [CHR_BANK_W-1:0] chr_inner_tab_t [CHR_INNER_N];
  typedef logic [CHR_BANK_W-1:0] chr_outer_tab_t [OUTER_BASE_N];

  function automatic prg_tab_t prg_wrap_table();
    prg_tab_t t;
    for (int i = 0; i < PRG_SPAN; i++) begin
      t[i] = PRG_BANK_W'(i % PRG_BANKS_8K);
    end
    return t;
  endfunction

  function automatic chr_inner_tab_t chr_inner_table();
    chr_inner_tab_t t;
    for (int i = 0; i < CHR_INNER_N; i++) begin
      t[i] = CHR_BANK_W'(i % CHR_BANKS_1K);
    end
    return t;
  endfunction

  function automatic chr_outer_tab_t chr_outer_table();
    chr_outer_tab_t t;
    for (int i = 0; i < OUTER_BASE_N; i++) begin
      t[i] = CHR_BANK_W'((i * CHR_INNER_N) % CHR_BANKS_1K);
    end
    return t;
  endfunction

  localparam prg_tab_t       PRG_WRAP_TAB  = prg_wrap_table();
  localparam chr_inner_tab_t CHR_INNER_TAB = chr_inner_table();
  localparam chr_outer_tab_t CHR_OUTER_TAB = chr_outer_table();

endpackage

`default_nettype wire

/* design/mcbsm_in_if.sv */
`default_nettype none

// Request channel: writes and lookups
interface mcbsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [mcbsm_pkg::CMD_W-1:0]   command;
  logic [mcbsm_pkg::ADDR_W-1:0]  address;
  logic [mcbsm_pkg::DATA_W-1:0]  value;
  logic                          prg_ram_write_enable;

  modport source (output valid, command, address, value, prg_ram_write_enable,
                  input ready);
  modport sink   (input valid, command, address, value, prg_ram_write_enable,
                  output ready);
endinterface

`default_nettype wire

/* design/mcbsm_out_if.sv */
`default_nettype none

// Result channel: translated address
interface mcbsm_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcbsm_pkg::MADDR_W-1:0] mapped_address;
  logic                          mapped;

  modport source (output valid, mapped_address, mapped, input ready);
  modport sink   (input valid, mapped_address, mapped, output ready);
endinterface

`default_nettype wire

/* design/multicart_bank_switch_mapper_top.sv */
// Channel   Modport  Word contents
// in_word   sink     command, address, value, prg_ram_write_enable
// out_word  source   mapped_address, mapped
//
// Two register stages: an input register, then translation logic into the
// result register. One word per cycle sustained while out_word is not
// stalled; each input word gives one result word.
// Register writes take effect for the word after them, in the cycle the write
// leaves the input register. Reset (rst_n low, synchronous) empties both
// stages and loads the bank registers with their power-up contents.
// A stall on out_word backs up through both stages to in_word.ready.
`default_nettype none
`include "multicart_bank_switch_mapper_top_macros.svh"

module multicart_bank_switch_mapper_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mcbsm_in_if.sink    in_word,
  mcbsm_out_if.source out_word
);
  import mcbsm_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  item_t               s1_item_r, s1_item_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MADDR_W-1:0]  out_maddr_r, out_maddr_nxt;
  logic                out_mapped_r, out_mapped_nxt;
  logic                out_adv;
  logic                s1_adv;
  logic                in_rdy;
  item_t               in_item;
  map_state_t          state;
  logic [MADDR_W-1:0]  xl_maddr;
  logic                xl_mapped;

  // handshake
  assign out_adv = !out_valid_r || out_word.ready;
  assign s1_adv  = s1_valid_r && out_adv;
  assign in_rdy  = !s1_valid_r || out_adv;
  assign in_word.ready = in_rdy;

  assign in_item.command              = in_word.command;
  assign in_item.address              = in_word.address;
  assign in_item.value                = in_word.value;
  assign in_item.prg_ram_write_enable = in_word.prg_ram_write_enable;

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_rdy) begin
      s1_valid_nxt = in_word.valid;
      if (in_word.valid) begin
        s1_item_nxt = in_item;
      end
    end
  end

  mcbsm_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_stb (s1_adv),
    .item   (s1_item_r),
    .state  (state)
  );

  mcbsm_xlate u_xlate (
    .item           (s1_item_r),
    .state          (state),
    .mapped_address (xl_maddr),
    .mapped         (xl_mapped)
  );

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_maddr_nxt  = out_maddr_r;
    out_mapped_nxt = out_mapped_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_maddr_nxt  = xl_maddr;
        out_mapped_nxt = xl_mapped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r    <= s1_item_nxt;
    out_maddr_r  <= out_maddr_nxt;
    out_mapped_r <= out_mapped_nxt;
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.mapped_address = out_maddr_r;
  assign out_word.mapped         = out_mapped_r;

  // checks
  `MCBSM_ASSERT_IMP(a_unmapped_zero, out_valid_r && !out_mapped_r, out_maddr_r == '0,
    "unmapped result carries a nonzero address")
  `MCBSM_ASSERT_NXT(a_stage_moves, s1_adv, out_valid_r,
    "word left the input register but no result followed")
  `MCBSM_ASSERT_NXT(a_bank_sel_write,
    s1_adv && (s1_item_r.command == CMD_CPU_WRITE)
      && ((s1_item_r.address & ADDR_MASK_BANK) == ADDR_BANK_SEL),
    state.bank_select == $past(s1_item_r.value),
    "bank-select write not applied")

endmodule

`default_nettype wire

/* design/mcbsm_regs.sv */
`default_nettype none

// Outer select, bank select and bank registers with CPU write decode
module mcbsm_regs (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_stb,
  input  wire mcbsm_pkg::item_t      item,
  output mcbsm_pkg::map_state_t      state
);
  import mcbsm_pkg::*;

  logic [5:0]             outer_select_r, outer_select_nxt;
  logic [DATA_W-1:0]      bank_select_r, bank_select_nxt;
  logic [7:0][DATA_W-1:0] bank_regs_r, bank_regs_nxt;
  logic                   is_write;
  logic                   in_ram_win;
  logic [ADDR_W-1:0]      masked;

  assign is_write   = wr_stb && (cmd_t'(item.command) == CMD_CPU_WRITE);
  assign in_ram_win = (item.address[15:13] == 3'b011);
  assign masked     = item.address & ADDR_MASK_BANK;

  // write decode
  always_comb begin
    outer_select_nxt = outer_select_r;
    bank_select_nxt  = bank_select_r;
    bank_regs_nxt    = bank_regs_r;
    if (is_write) begin
      if (in_ram_win) begin
        if (item.prg_ram_write_enable) begin
          outer_select_nxt = item.address[5:0];
        end
      end else if (masked == ADDR_BANK_SEL) begin
        bank_select_nxt = item.value;
      end else if (masked == ADDR_BANK_DATA) begin
        bank_regs_nxt[bank_select_r[2:0]] = item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_select_r <= '0;
      bank_select_r  <= '0;
      bank_regs_r    <= BANK_REGS_RESET;
    end else begin
      outer_select_r <= outer_select_nxt;
      bank_select_r  <= bank_select_nxt;
      bank_regs_r    <= bank_regs_nxt;
    end
  end

  assign state.outer_select = outer_select_r;
  assign state.bank_select  = bank_select_r;
  assign state.bank_regs    = bank_regs_r;

endmodule

`default_nettype wire

/* design/mcbsm_xlate.sv */
`default_nettype none

// PRG and CHR address translation
module mcbsm_xlate (
  input  wire mcbsm_pkg::item_t               item,
  input  wire mcbsm_pkg::map_state_t          state,
  output logic [mcbsm_pkg::MADDR_W-1:0]       mapped_address,
  output logic                                mapped
);
  import mcbsm_pkg::*;

  logic [1:0]            prg_win;
  logic [3:0]            prg_inner;
  logic [PRG_BANK_W-1:0] prg_bank;
  logic [PRG_BANK_W-1:0] prg_wrap;
  logic [2:0]            chr_slot;
  logic [DATA_W-1:0]     chr_inner;
  logic [CHR_BANK_W:0]   chr_sum;
  logic [CHR_BANK_W:0]   chr_wrap;
  logic                  swapped;

  // PRG: 8K windows
  assign prg_win = item.address[14:13];
  assign swapped = state.bank_select[6];

  always_comb begin
    case (prg_win)
      2'd0:    prg_inner = swapped ? PRG_FIXED_2ND_LAST : state.bank_regs[6][3:0];
      2'd1:    prg_inner = state.bank_regs[7][3:0];
      2'd2:    prg_inner = swapped ? state.bank_regs[6][3:0] : PRG_FIXED_2ND_LAST;
      default: prg_inner = PRG_FIXED_LAST;
    endcase
  end

  assign prg_bank = state.outer_select[3]
                  ? {state.outer_select[2:0], state.outer_select[5:4], prg_win}
                  : {state.outer_select[2:0], prg_inner};
  assign prg_wrap = PRG_WRAP_TAB[prg_bank];

  // CHR: 1K windows, halves swapped by bit 7
  assign chr_slot = item.address[12:10] ^ {state.bank_select[7], 2'b00};

  always_comb begin
    case (chr_slot)
      3'd0:    chr_inner = {state.bank_regs[0][7:1], 1'b0};
      3'd1:    chr_inner = {state.bank_regs[0][7:1], 1'b1};
      3'd2:    chr_inner = {state.bank_regs[1][7:1], 1'b0};
      3'd3:    chr_inner = {state.bank_regs[1][7:1], 1'b1};
      3'd4:    chr_inner = state.bank_regs[2];
      3'd5:    chr_inner = state.bank_regs[3];
      3'd6:    chr_inner = state.bank_regs[4];
      default: chr_inner = state.bank_regs[5];
    endcase
  end

  // wrap outer and inner parts separately, then one correction
  assign chr_sum  = {1'b0, CHR_OUTER_TAB[state.outer_select[2:0]]}
                  + {1'b0, CHR_INNER_TAB[chr_inner[CHR_INNER_W-1:0]]};
  assign chr_wrap = (chr_sum >= (CHR_BANK_W+1)'(CHR_BANKS_1K))
                  ? chr_sum - (CHR_BANK_W+1)'(CHR_BANKS_1K) : chr_sum;

  // result select
  always_comb begin
    mapped_address = '0;
    mapped         = 1'b0;
    case (item.command)
      CMD_CPU_READ: begin
        if (item.address[15]) begin
          mapped_address = {prg_wrap, item.address[12:0]};
          mapped         = 1'b1;
        end
      end
      CMD_PPU_READ: begin
        if (item.address[15:13] == 3'b000) begin
          mapped_address = {chr_wrap[CHR_BANK_W-1:0], item.address[9:0]};
          mapped         = 1'b1;
        end
      end
      default: begin
        mapped_address = '0;
        mapped         = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* dv/mapper_translation_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the mapper, tracks bank state from accepted
// words and checks every result word against its predicted translation.
module mapper_translation_checker (
  input  logic clk,
  input  logic rst_n,
  mcbsm_in_if  in_mon,
  mcbsm_out_if out_mon,
  output int   fail_count,
  output int   pending
);
  import mcbsm_pkg::*;

  // Address windows and write decode
  localparam logic [ADDR_W-1:0] OUTER_WIN_LO     = 16'h6000;
  localparam logic [ADDR_W-1:0] PRG_WIN_LO       = 16'h8000;
  localparam logic [ADDR_W-1:0] CHR_WIN_END      = 16'h2000;
  localparam logic [ADDR_W-1:0] BANK_DECODE_MASK = 16'hE001;
  localparam logic [ADDR_W-1:0] BANK_SELECT_ADDR = 16'h8000;
  localparam logic [ADDR_W-1:0] BANK_DATA_ADDR   = 16'h8001;

  // Hardwired PRG banks, low nibble
  localparam logic [3:0] FIXED_BANK_2ND_LAST = 4'hE;
  localparam logic [3:0] FIXED_BANK_LAST     = 4'hF;

  typedef struct packed {
    logic [MADDR_W-1:0] phys_addr;
    logic               hit;
  } map_result_t;

  // Predicted mapper state
  logic [5:0]        outer_sel;
  logic [DATA_W-1:0] bank_sel;
  logic [DATA_W-1:0] bank_regs [8];

  map_result_t expected_maps [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MAP MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // 8K CPU windows
  function automatic logic [MADDR_W-1:0] prg_phys(input logic [ADDR_W-1:0] a);
    logic [1:0] win;
    logic [3:0] inner;
    int         bank;
    win = a[14:13];
    if (outer_sel[3]) begin
      // 32K mode: bank comes from outer bits and the window bits
      bank = {outer_sel[2:0], outer_sel[5:4], win};
    end else begin
      case (win)
        2'd0:    inner = bank_sel[6] ? FIXED_BANK_2ND_LAST : bank_regs[6][3:0];
        2'd1:    inner = bank_regs[7][3:0];
        2'd2:    inner = bank_sel[6] ? bank_regs[6][3:0] : FIXED_BANK_2ND_LAST;
        default: inner = FIXED_BANK_LAST;
      endcase
      bank = {outer_sel[2:0], inner};
    end
    bank = bank % PRG_BANKS_8K;
    return MADDR_W'((bank << 13) | int'(a[12:0]));
  endfunction

  // 1K PPU windows; regs 0 and 1 cover 2K pairs
  function automatic logic [MADDR_W-1:0] chr_phys(input logic [ADDR_W-1:0] a);
    logic [2:0] slot;
    logic [6:0] inner;
    int         bank;
    slot = a[12:10] ^ {bank_sel[7], 2'b00};
    case (slot)
      3'd0:    inner = {bank_regs[0][6:1], 1'b0};
      3'd1:    inner = {bank_regs[0][6:1], 1'b1};
      3'd2:    inner = {bank_regs[1][6:1], 1'b0};
      3'd3:    inner = {bank_regs[1][6:1], 1'b1};
      default: inner = bank_regs[slot - 3'd2][6:0];
    endcase
    bank = {outer_sel[2:0], inner};
    bank = bank % CHR_BANKS_1K;
    return MADDR_W'((bank << 10) | int'(a[9:0]));
  endfunction

  // Applies one word to the state and returns its result
  function automatic map_result_t translate_word(input item_t w);
    map_result_t       r;
    logic [ADDR_W-1:0] decoded;
    r = '0;
    decoded = w.address & BANK_DECODE_MASK;
    case (w.command)
      CMD_CPU_WRITE: begin
        if (w.address >= OUTER_WIN_LO && w.address < PRG_WIN_LO) begin
          if (w.prg_ram_write_enable) outer_sel = w.address[5:0];
        end else if (w.address >= PRG_WIN_LO) begin
          if (decoded == BANK_SELECT_ADDR) begin
            bank_sel = w.value;
          end else if (decoded == BANK_DATA_ADDR) begin
            bank_regs[bank_sel[2:0]] = w.value;
          end
        end
      end
      CMD_CPU_READ: begin
        if (w.address >= PRG_WIN_LO) begin
          r.phys_addr = prg_phys(w.address);
          r.hit       = 1'b1;
        end
      end
      CMD_PPU_READ: begin
        if (w.address < CHR_WIN_END) begin
          r.phys_addr = chr_phys(w.address);
          r.hit       = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sample both channels at the edge; results are checked before new words
  always @(posedge clk) begin
    item_t       w;
    map_result_t exp_map;
    if (!rst_n) begin
      outer_sel = '0;
      bank_sel  = '0;
      bank_regs = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};
      expected_maps.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_maps.size() == 0) begin
          report_mismatch($sformatf("unexpected result word addr=%05h mapped=%0b",
                                    out_mon.mapped_address, out_mon.mapped));
        end else begin
          exp_map = expected_maps.pop_front();
          if (out_mon.mapped_address !== exp_map.phys_addr) begin
            report_mismatch($sformatf("mapped_address got %05h want %05h",
                                      out_mon.mapped_address, exp_map.phys_addr));
          end
          if (out_mon.mapped !== exp_map.hit) begin
            report_mismatch($sformatf("mapped got %0b want %0b",
                                      out_mon.mapped, exp_map.hit));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        w.command              = in_mon.command;
        w.address              = in_mon.address;
        w.value                = in_mon.value;
        w.prg_ram_write_enable = in_mon.prg_ram_write_enable;
        expected_maps.push_back(translate_word(w));
      end
    end
    pending = expected_maps.size();
  end

endmodule

/* dv/multicart_bank_switch_mapper_top_tb.sv */
`timescale 1ns / 100ps

module multicart_bank_switch_mapper_top_tb;
  import mcbsm_pkg::*;

  // Command code the block leaves undefined
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 950;
  localparam int LONG_HOLD    = 80;

  logic clk;
  logic rst_n;
  int   map_fails;
  int   maps_pending;
  logic hold_results;
  int   burst_left;
  int   tx_cap;
  int   tx_count;

  mcbsm_in_if  in_word ();
  mcbsm_out_if out_word ();

  multicart_bank_switch_mapper_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  mapper_translation_checker u_map_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_word),
    .out_mon    (out_word),
    .fail_count (map_fails),
    .pending    (maps_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap ceiling for a stretch of words: none, short or long
  function automatic int pick_gap_cap();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 16;
    endcase
  endfunction

  function automatic item_t mk_word(input logic [CMD_W-1:0] cmd,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [DATA_W-1:0] val,
                                    input logic we);
    item_t w;
    w.command              = cmd;
    w.address              = addr;
    w.value                = val;
    w.prg_ram_write_enable = we;
    return w;
  endfunction

  // Offer one word after a random gap; returns at the accepting edge
  task automatic send_word(input item_t w);
    int gap;
    if (tx_count % 64 == 0) tx_cap = pick_gap_cap();
    tx_count++;
    gap = (burst_left > 0) ? 0 : $urandom_range(0, tx_cap);
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid                <= 1'b1;
    in_word.command              <= w.command;
    in_word.address              <= w.address;
    in_word.value                <= w.value;
    in_word.prg_ram_write_enable <= w.prg_ram_write_enable;
    do @(posedge clk); while (!in_word.ready);
  endtask

  // Stall the sender until every expected word has come back
  task automatic drain_results();
    in_word.valid <= 1'b0;
    @(posedge clk);
    wait (maps_pending == 0);
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    int rx_cap;
    int rx_count;
    int gap;
    rx_cap   = 0;
    rx_count = 0;
    out_word.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_results) begin
        out_word.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      if (rx_count % 50 == 0) rx_cap = pick_gap_cap();
      rx_count++;
      gap = $urandom_range(0, rx_cap);
      if (gap > 0) begin
        out_word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      do @(posedge clk); while (!out_word.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    item_t directed [$];
    int    counted;
    int    kind;
    hold_results = 1'b0;
    burst_left   = 0;
    tx_cap       = 0;
    tx_count     = 0;
    rst_n                        <= 1'b0;
    in_word.valid                <= 1'b0;
    in_word.command              <= CMD_CPU_WRITE;
    in_word.address              <= '0;
    in_word.value                <= '0;
    in_word.prg_ram_write_enable <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset-state lookups, window edges, ignored writes, mirrored decode
    directed = '{
      mk_word(CMD_CPU_READ,  16'h8000, 8'h00, 1'b0),
      mk_word(CMD_CPU_READ,  16'hA123, 8'hFF, 1'b1),
      mk_word(CMD_CPU_READ,  16'hC000, 8'h00, 1'b0),
      mk_word(CMD_CPU_READ,  16'hFFFF, 8'h00, 1'b0),
      mk_word(CMD_CPU_READ,  16'h7FFF, 8'h00, 1'b0),
      mk_word(CMD_CPU_READ,  16'h0000, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'h0000, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'h1FFF, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'h2000, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'hFFFF, 8'h00, 1'b0),
      mk_word(CMD_UNUSED,    16'hFFFF, 8'hFF, 1'b1),
      mk_word(CMD_CPU_WRITE, 16'h5FFF, 8'hFF, 1'b1),
      mk_word(CMD_CPU_WRITE, 16'h7FFF, 8'hFF, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'h8000, 8'hC7, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'h8001, 8'hFF, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'hA000, 8'h55, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'h9FFE, 8'h46, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'h9FFF, 8'h8B, 1'b0),
      mk_word(CMD_CPU_READ,  16'h8000, 8'h00, 1'b0),
      mk_word(CMD_CPU_READ,  16'hDFFF, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'h0400, 8'h00, 1'b0),
      mk_word(CMD_CPU_WRITE, 16'h6000, 8'h00, 1'b1),
      mk_word(CMD_CPU_WRITE, 16'h7FFF, 8'h00, 1'b1),
      mk_word(CMD_CPU_READ,  16'hE000, 8'h00, 1'b0),
      mk_word(CMD_PPU_READ,  16'h1C00, 8'h00, 1'b0)
    };
    foreach (directed[i]) send_word(directed[i]);

    // Random traffic, mostly well-formed register updates and lookups
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        send_word(mk_word(CMD_CPU_WRITE, 16'h8000 | (ADDR_W'($urandom) & 16'h1FFE),
                          DATA_W'($urandom), 1'($urandom)));
        send_word(mk_word(CMD_CPU_WRITE, 16'h8001 | (ADDR_W'($urandom) & 16'h1FFE),
                          DATA_W'($urandom), 1'($urandom)));
        counted += 2;
      end else if (kind < 30) begin
        send_word(mk_word(CMD_CPU_WRITE, 16'h6000 | (ADDR_W'($urandom) & 16'h1FFF),
                          DATA_W'($urandom), 1'($urandom_range(0, 3) != 0)));
        counted++;
      end else if (kind < 60) begin
        send_word(mk_word(CMD_CPU_READ, 16'h8000 | (ADDR_W'($urandom) & 16'h7FFF),
                          DATA_W'($urandom), 1'($urandom)));
        counted++;
      end else if (kind < 88) begin
        send_word(mk_word(CMD_PPU_READ, ADDR_W'($urandom) & 16'h1FFF,
                          DATA_W'($urandom), 1'($urandom)));
        counted++;
      end else begin
        // Noise: any command, any address
        send_word(mk_word(CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom),
                          DATA_W'($urandom), 1'($urandom)));
        counted++;
      end
      if (counted >= 300 && counted < 302 && !hold_results && burst_left == 0) begin
        // Long result stall while words keep coming back to back
        hold_results = 1'b1;
        burst_left   = 40;
      end
      if (counted >= 600 && counted < 602) drain_results();
    end

    in_word.valid <= 1'b0;
    @(posedge clk);
    wait (maps_pending == 0);
    repeat (8) @(posedge clk);
    if (map_fails == 0 && maps_pending == 0) begin
      $display("multicart_bank_switch_mapper_top verification clean");
    end else begin
      $display("multicart_bank_switch_mapper_top verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("multicart_bank_switch_mapper_top verification failed");
    $finish;
  end

endmodule
